### rtl/scan_position_lru_table_assert.svh
// Assertion macros for the scan position table RTL.
`ifndef SCAN_POSITION_LRU_TABLE_ASSERT_SVH
`define SCAN_POSITION_LRU_TABLE_ASSERT_SVH

// Check that cons holds in the same cycle as ante.
`define SPLT_ASSERT_SAME(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) else $error(msg);

// Check that cons holds in the cycle after ante.
`define SPLT_ASSERT_NEXT(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) else $error(msg);

`endif

### rtl/splt_pkg.sv
package splt_pkg;

  localparam int ENTRIES = 20;
  localparam int WORD_W  = 32;
  localparam int LOG2_W  = 3;

  localparam logic [LOG2_W-1:0] INTERVAL_LOG2_RESET = 3'd4;

  localparam logic OP_GET    = 1'b0;
  localparam logic OP_REPORT = 1'b1;

  typedef struct packed {
    logic [WORD_W-1:0] tablespace;
    logic [WORD_W-1:0] database;
    logic [WORD_W-1:0] relation;
    logic [WORD_W-1:0] position;
  } entry_t;

  // Controller to datapath commands.
  typedef struct packed {
    logic load;
    logic search;
    logic commit;
  } cmd_t;

endpackage

### rtl/scan_position_lru_table.sv
// Channel  Handshake              Word
// in       in_valid / in_ready    opcode, tablespace_id, database_id, relation_id,
//                                 block_number, table_length
// out      out_valid / out_ready  start_block, key_found, table_touched
// cfg      cfg_we                 cfg_wdata (report_interval_log2)
//
// Each request goes through accept, parallel key compare over all entries,
// then move-to-front and output load. One request is in flight at a time.
// A result waiting at the output stalls the final step, and no new request
// is accepted until that step completes. Synchronous reset restores the table
// (key 0, position all ones) and sets the report interval log2 to 4.
module scan_position_lru_table
  import splt_pkg::*;
(
  input  logic              clk,
  input  logic              rst,
  input  logic              cfg_we,
  input  logic [LOG2_W-1:0] cfg_wdata,
  input  logic              in_valid,
  output logic              in_ready,
  input  logic              opcode,
  input  logic [WORD_W-1:0] tablespace_id,
  input  logic [WORD_W-1:0] database_id,
  input  logic [WORD_W-1:0] relation_id,
  input  logic [WORD_W-1:0] block_number,
  input  logic [WORD_W-1:0] table_length,
  output logic              out_valid,
  input  logic              out_ready,
  output logic [WORD_W-1:0] start_block,
  output logic              key_found,
  output logic              table_touched
);

  `include "scan_position_lru_table_assert.svh"

  cmd_t cmd;

  splt_ctrl u_ctrl (
    .clk       (clk),
    .rst       (rst),
    .in_valid  (in_valid),
    .in_ready  (in_ready),
    .out_valid (out_valid),
    .out_ready (out_ready),
    .cmd       (cmd)
  );

  splt_dp u_dp (
    .clk           (clk),
    .rst           (rst),
    .cmd           (cmd),
    .cfg_we        (cfg_we),
    .cfg_wdata     (cfg_wdata),
    .opcode        (opcode),
    .tablespace_id (tablespace_id),
    .database_id   (database_id),
    .relation_id   (relation_id),
    .block_number  (block_number),
    .table_length  (table_length),
    .start_block   (start_block),
    .key_found     (key_found),
    .table_touched (table_touched)
  );

  `SPLT_ASSERT_SAME(a_no_overwrite, cmd.commit, !out_valid || out_ready, "result overwritten")
  `SPLT_ASSERT_NEXT(a_load_search, in_valid && in_ready, cmd.search, "no search after accept")
  `SPLT_ASSERT_NEXT(a_commit_valid, cmd.commit, out_valid, "commit without output word")
  `SPLT_ASSERT_SAME(a_untouched_zero, out_valid && !table_touched, !key_found && (start_block == '0), "untouched result not zero")

endmodule

### rtl/splt_ctrl.sv
module splt_ctrl
  import splt_pkg::*;
(
  input  logic clk,
  input  logic rst,
  input  logic in_valid,
  output logic in_ready,
  output logic out_valid,
  input  logic out_ready,
  output cmd_t cmd
);

  typedef enum logic [1:0] {
    IDLE,
    SEARCH,
    COMMIT
  } state_t;

  state_t state;

  assign in_ready   = (state == IDLE);
  assign cmd.load   = in_valid && (state == IDLE);
  assign cmd.search = (state == SEARCH);
  // Hold the commit while an earlier word still waits at the output.
  assign cmd.commit = (state == COMMIT) && (!out_valid || out_ready);

  always_ff @(posedge clk) begin
    if (rst) begin
      state     <= IDLE;
      out_valid <= 1'b0;
    end else begin
      if (cmd.commit) begin
        out_valid <= 1'b1;
      end else if (out_ready) begin
        out_valid <= 1'b0;
      end
      case (state)
        IDLE: begin
          if (cmd.load) begin
            state <= SEARCH;
          end
        end
        SEARCH: begin
          state <= COMMIT;
        end
        COMMIT: begin
          if (cmd.commit) begin
            state <= IDLE;
          end
        end
        default: begin
          state <= IDLE;
        end
      endcase
    end
  end

endmodule

### rtl/splt_dp.sv
module splt_dp
  import splt_pkg::*;
(
  input  logic              clk,
  input  logic              rst,
  input  cmd_t              cmd,
  input  logic              cfg_we,
  input  logic [LOG2_W-1:0] cfg_wdata,
  input  logic              opcode,
  input  logic [WORD_W-1:0] tablespace_id,
  input  logic [WORD_W-1:0] database_id,
  input  logic [WORD_W-1:0] relation_id,
  input  logic [WORD_W-1:0] block_number,
  input  logic [WORD_W-1:0] table_length,
  output logic [WORD_W-1:0] start_block,
  output logic              key_found,
  output logic              table_touched
);

  logic [LOG2_W-1:0] interval_log2;

  logic              req_op;
  logic [WORD_W-1:0] req_ts;
  logic [WORD_W-1:0] req_db;
  logic [WORD_W-1:0] req_rel;
  logic [WORD_W-1:0] req_blk;
  logic [WORD_W-1:0] req_len;
  logic              req_touch;

  entry_t            tbl [ENTRIES];

  logic [ENTRIES-1:0] match;
  logic [ENTRIES-1:0] ahead;
  logic [ENTRIES-1:0] first;
  logic [WORD_W-1:0]  pos_sel;
  logic [WORD_W-1:0]  blk_mask;
  logic               in_touch;

  logic               hit;
  logic [ENTRIES-1:0] shift_en;
  logic [WORD_W-1:0]  val;

  // Off-interval reports leave the table alone.
  assign blk_mask = ~({WORD_W{1'b1}} << interval_log2);
  assign in_touch = (opcode == OP_GET) || ((block_number & blk_mask) == '0);

  always_comb begin
    pos_sel = '0;
    for (int i = 0; i < ENTRIES; i++) begin
      match[i] = (tbl[i].tablespace == req_ts) && (tbl[i].database == req_db) &&
                 (tbl[i].relation == req_rel);
    end
    for (int i = 0; i < ENTRIES; i++) begin
      ahead[i] = |(match & ((ENTRIES'(1) << i) - ENTRIES'(1)));
      first[i] = match[i] && !ahead[i];
      pos_sel  = pos_sel | (tbl[i].position & {WORD_W{first[i]}});
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      interval_log2 <= INTERVAL_LOG2_RESET;
    end else if (cfg_we) begin
      interval_log2 <= cfg_wdata;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.load) begin
      req_op    <= opcode;
      req_ts    <= tablespace_id;
      req_db    <= database_id;
      req_rel   <= relation_id;
      req_blk   <= block_number;
      req_len   <= table_length;
      req_touch <= in_touch;
    end
    // Entry i shifts down when no match sits in front of it.
    if (cmd.search) begin
      hit      <= |match;
      shift_en <= ~ahead;
      if (req_op == OP_REPORT) begin
        val <= req_blk;
      end else if (|match) begin
        val <= pos_sel;
      end else begin
        val <= '0;
      end
    end
    if (cmd.commit) begin
      table_touched <= req_touch;
      key_found     <= req_touch && hit;
      if (req_touch && (req_op == OP_GET) && (val < req_len)) begin
        start_block <= val;
      end else begin
        start_block <= '0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      for (int i = 0; i < ENTRIES; i++) begin
        tbl[i] <= '{tablespace: '0, database: '0, relation: '0, position: '1};
      end
    end else if (cmd.commit && req_touch) begin
      for (int i = 1; i < ENTRIES; i++) begin
        if (shift_en[i]) begin
          tbl[i] <= tbl[i-1];
        end
      end
      tbl[0] <= '{tablespace: req_ts, database: req_db, relation: req_rel, position: val};
    end
  end

endmodule
